// ===== rtl/core/pfsa_pkg.sv =====
// Shared types and defaults for the page frame stack allocator.
package pfsa_pkg;

  localparam int unsigned POOL_BASE_FRAME_DEF = 16384;
  localparam int unsigned POOL_FRAMES_DEF     = 49152;
  localparam int unsigned PAGE_SHIFT_DEF      = 12;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_FULL  = 2'd3
  } pfsa_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } pfsa_state_t;

  typedef struct packed {
    logic load;     // capture request
    logic exec;     // run push/pop
    logic pop_out;  // drive result from read data
  } pfsa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic empty;
  } pfsa_sts_t;

endpackage

// ===== rtl/core/pfsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pfsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/pfsa_ctrl.sv =====
// Request sequencer for the page frame stack allocator.
module pfsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pfsa_pkg::pfsa_sts_t sts,
  output pfsa_pkg::pfsa_cmd_t cmd
);

  pfsa_pkg::pfsa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    busy        = 1'b1;
    unique case (state_r)
      pfsa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = pfsa_pkg::S_EXEC;
        end
      end
      pfsa_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_alloc && !sts.empty) begin
          state_nxt = pfsa_pkg::S_WAIT;
        end else begin
          state_nxt = pfsa_pkg::S_IDLE;
        end
      end
      pfsa_pkg::S_WAIT: begin
        cmd.pop_out = 1'b1;
        state_nxt   = pfsa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pfsa_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == pfsa_pkg::S_EXEC)
    else $error("load did not lead to exec");
  a_wait_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pfsa_pkg::S_WAIT |-> $past(state_r) == pfsa_pkg::S_EXEC)
    else $error("wait not entered from exec");
  a_one_hot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.pop_out}))
    else $error("overlapping commands");
`endif

endmodule

// ===== rtl/core/pfsa_dp.sv =====
// Datapath: free stack memory, depth and untouched mark, checks and result registers.
module pfsa_dp #(
  parameter int unsigned POOL_BASE_FRAME = pfsa_pkg::POOL_BASE_FRAME_DEF,
  parameter int unsigned POOL_FRAMES     = pfsa_pkg::POOL_FRAMES_DEF,
  parameter int unsigned PAGE_SHIFT      = pfsa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_kind,
  input  logic [31:0]         in_free_address,
  input  pfsa_pkg::pfsa_cmd_t cmd,
  output pfsa_pkg::pfsa_sts_t sts,
  output logic                out_strobe,
  output logic [1:0]          out_status,
  output logic [31:0]         out_page_address
);

  localparam int unsigned IDX_W   = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int unsigned DEPTH_W = $clog2(POOL_FRAMES + 1);
  localparam logic [DEPTH_W-1:0] FRAMES_D = DEPTH_W'(POOL_FRAMES);
  localparam logic [IDX_W-1:0]   TOP_OFF  = IDX_W'(POOL_FRAMES - 1);
  localparam logic [32:0] LO_FRAME  = 33'(POOL_BASE_FRAME);
  localparam logic [32:0] HI_FRAME  = 33'(POOL_BASE_FRAME) + 33'(POOL_FRAMES);
  localparam logic [31:0] PAGE_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

  logic               kind_r;
  logic [31:0]        addr_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] mark_r, mark_nxt;
  logic               use_rst_r, use_rst_nxt;
  logic [IDX_W-1:0]   rst_val_r, rst_val_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [31:0]        out_addr_r, out_addr_nxt;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr, ram_wdata, ram_rdata;

  logic [32:0]        frame;
  logic               addr_ok;
  logic [IDX_W-1:0]   push_off;
  logic [IDX_W-1:0]   pop_idx;
  logic [IDX_W-1:0]   pop_off;
  logic [63:0]        pop_frame;

  pfsa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_FRAMES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign frame    = 33'(addr_r >> PAGE_SHIFT);
  assign addr_ok  = (frame >= LO_FRAME) && (frame < HI_FRAME) &&
                    ((addr_r & PAGE_MASK) == 32'd0);
  assign push_off = IDX_W'(frame - LO_FRAME);
  assign pop_idx  = IDX_W'(depth_r - DEPTH_W'(1));
  assign pop_off  = use_rst_r ? rst_val_r : ram_rdata;
  assign pop_frame = 64'(POOL_BASE_FRAME) + 64'(pop_off);

  assign sts.is_alloc = !kind_r;
  assign sts.empty    = (depth_r == '0);

  assign ram_waddr = IDX_W'(depth_r);
  assign ram_wdata = push_off;
  assign ram_raddr = pop_idx;

  always_comb begin
    depth_nxt      = depth_r;
    mark_nxt       = mark_r;
    use_rst_nxt    = use_rst_r;
    rst_val_nxt    = rst_val_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    if (cmd.exec) begin
      if (!kind_r) begin
        if (depth_r == '0) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = pfsa_pkg::ST_EMPTY;
          out_addr_nxt   = '0;
        end else begin
          depth_nxt   = depth_r - DEPTH_W'(1);
          ram_re      = 1'b1;
          use_rst_nxt = DEPTH_W'(pop_idx) < mark_r;
          rst_val_nxt = TOP_OFF - pop_idx;
        end
      end else begin
        out_strobe_nxt = 1'b1;
        out_addr_nxt   = '0;
        if (!addr_ok) begin
          out_status_nxt = pfsa_pkg::ST_BAD;
        end else if (depth_r == FRAMES_D) begin
          out_status_nxt = pfsa_pkg::ST_FULL;
        end else begin
          out_status_nxt = pfsa_pkg::ST_OK;
          ram_we         = 1'b1;
          depth_nxt      = depth_r + DEPTH_W'(1);
          if (depth_r < mark_r) begin
            mark_nxt = depth_r;
          end
        end
      end
    end else if (cmd.pop_out) begin
      out_strobe_nxt = 1'b1;
      out_status_nxt = pfsa_pkg::ST_OK;
      out_addr_nxt   = 32'(pop_frame << PAGE_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= FRAMES_D;
      mark_r       <= FRAMES_D;
      out_strobe_r <= 1'b0;
    end else begin
      depth_r      <= depth_nxt;
      mark_r       <= mark_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      addr_r <= in_free_address;
    end
    use_rst_r    <= use_rst_nxt;
    rst_val_r    <= rst_val_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_page_address = out_addr_r;

`ifndef ASSERT_OFF
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= FRAMES_D)
    else $error("stack depth beyond pool size");
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= FRAMES_D)
    else $error("untouched mark beyond pool size");
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_status_r != pfsa_pkg::ST_OK |-> out_addr_r == '0)
    else $error("nonzero address on failed transfer");
  a_depth_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(depth_r))
    else $error("depth changed without exec");
`endif

endmodule

// ===== rtl/core/page_frame_stack_allocator_core.sv =====
// Top level of the page frame stack allocator: controller plus datapath.
//
//  channel  ports                                 transfer
//  request  start, busy, in_kind, in_free_address  start && !busy
//  result   out_strobe, out_status, out_page_address  out_strobe (one cycle)
//
// Free and empty-pool allocate: the EXEC state checks the captured request and
// loads the result register. Allocate from a nonempty pool: the EXEC state reads
// the stack memory and the WAIT state loads the result from its registered read data.
// busy stays high until the result register is loaded; a new request can be
// taken in the cycle the strobe is shown. Synchronous active-low reset loads a
// full stack; no memory clearing pass. The receiver cannot stall results.
module page_frame_stack_allocator_core #(
  parameter int unsigned POOL_BASE_FRAME = pfsa_pkg::POOL_BASE_FRAME_DEF,
  parameter int unsigned POOL_FRAMES     = pfsa_pkg::POOL_FRAMES_DEF,
  parameter int unsigned PAGE_SHIFT      = pfsa_pkg::PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_free_address,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [31:0] out_page_address
);

  pfsa_pkg::pfsa_cmd_t cmd;
  pfsa_pkg::pfsa_sts_t sts;

  pfsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pfsa_dp #(
    .POOL_BASE_FRAME (POOL_BASE_FRAME),
    .POOL_FRAMES     (POOL_FRAMES),
    .PAGE_SHIFT      (PAGE_SHIFT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_free_address  (in_free_address),
    .cmd              (cmd),
    .sts              (sts),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_page_address (out_page_address)
  );

endmodule
